@@ rtl/core/rsc_pkg.sv @@
// Shared types, constants and helpers of the rational soft clipper.
package rsc_pkg;

   // Default sizes of the sample and of the gain fraction.
   localparam int SAMPLE_WIDTH_DEFAULT   = 16;
   localparam int GAIN_FRAC_BITS_DEFAULT = 12;

   // Gain register: unsigned Q4.12, reset to one half.
   localparam int               GAIN_WIDTH = 16;
   localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 16'd2048;

   // Register port: 32-bit data, byte addresses decoded to word indexes.
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_INDEX_LSB  = 2;
   localparam int CSR_INDEX_BITS = CSR_ADDR_WIDTH - CSR_INDEX_LSB;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_DRIVE_GAIN = '0;

   // Sideband that travels with each item through the pipeline.
   typedef struct packed {
      logic neg;   // product was negative
      logic big;   // scaled magnitude is three or more
   } flags_type;

   // Fraction bits used inside the curve: the sample fraction, at most fifteen.
   function automatic int work_frac(input int sample_width);
      int frac;
      frac = sample_width - 1;
      return (frac < 15) ? frac : 15;
   endfunction

endpackage

@@ rtl/core/rsc_csr.sv @@
// Configuration register block: drive gain behind an APB-style port.
module rsc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rsc_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [rsc_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [rsc_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready,
   output logic [rsc_pkg::GAIN_WIDTH-1:0]       drive_gain
);

   logic [rsc_pkg::CSR_INDEX_BITS-1:0] index;
   logic                               write_en;
   logic [rsc_pkg::GAIN_WIDTH-1:0]     gain_ff;
   logic [rsc_pkg::GAIN_WIDTH-1:0]     gain_in;

   // Decode the word index and the write strobe
   assign index    = paddr[rsc_pkg::CSR_ADDR_WIDTH-1:rsc_pkg::CSR_INDEX_LSB];
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;

   // Take the low half of the written word as the new gain
   always_comb begin
      gain_in = gain_ff;
      if (write_en && (index == rsc_pkg::REG_DRIVE_GAIN)) begin
         gain_in = pwdata[rsc_pkg::GAIN_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= rsc_pkg::GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   // Read back the gain, zero elsewhere
   always_comb begin
      prdata = '0;
      if (index == rsc_pkg::REG_DRIVE_GAIN) begin
         prdata = rsc_pkg::CSR_DATA_WIDTH'(gain_ff);
      end
   end

   assign drive_gain = gain_ff;

endmodule

@@ rtl/core/rsc_poly.sv @@
// Front pipeline: gain scaling, square, numerator and denominator of the curve.
module rsc_poly #(
   parameter int SAMPLE_WIDTH   = rsc_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int GAIN_FRAC_BITS = rsc_pkg::GAIN_FRAC_BITS_DEFAULT,
   parameter int NUM_WIDTH      = 53,
   parameter int DEN_WIDTH      = 37
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
   input  logic [rsc_pkg::GAIN_WIDTH-1:0] gain,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [NUM_WIDTH-1:0]           out_num,
   output logic [DEN_WIDTH-1:0]           out_den,
   output rsc_pkg::flags_type             out_flags
);

   localparam int FRAC  = SAMPLE_WIDTH - 1;
   localparam int WF    = rsc_pkg::work_frac(SAMPLE_WIDTH);
   localparam int PW    = SAMPLE_WIDTH + rsc_pkg::GAIN_WIDTH;
   localparam int SHIFT = GAIN_FRAC_BITS + FRAC - WF;
   localparam int MW    = WF + 2;
   localparam int M2W   = 2 * MW;
   localparam int SUMW  = 2 * WF + 6;
   localparam logic [SUMW-1:0] C27       = SUMW'(27) << (2 * WF);
   localparam logic [PW-1:0]   THREE_FIX = PW'(3) << WF;

   // Stage valid bits and per-stage advance
   logic v1_ff, v2_ff, v3_ff;
   logic r1, r2, r3;

   // Stage 1: magnitude times gain
   logic [SAMPLE_WIDTH-1:0] raw;
   logic [SAMPLE_WIDTH-1:0] mag;
   logic [PW-1:0]           prod_in, prod_ff;
   rsc_pkg::flags_type      f1_in, f1_ff;

   // Stage 2: truncate, range check, square
   logic [PW-1:0]           mfull;
   logic [MW-1:0]           m_in, m_ff;
   logic [M2W-1:0]          m2_in, m2_ff;
   rsc_pkg::flags_type      f2_in, f2_ff;

   // Stage 3: numerator and denominator
   logic [SUMW-1:0]         sum;
   logic [NUM_WIDTH-1:0]    num_in, num_ff;
   logic [DEN_WIDTH-1:0]    den_in, den_ff;
   rsc_pkg::flags_type      f3_ff;

   // Advance a stage when it is empty or its successor takes its item
   assign r3       = !v3_ff || out_ready;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   // Stage 1 logic
   assign raw       = in_sample;
   assign mag       = raw[SAMPLE_WIDTH-1] ? (~raw + 1'b1) : raw;
   assign prod_in   = PW'(mag) * PW'(gain);
   assign f1_in.neg = raw[SAMPLE_WIDTH-1];
   assign f1_in.big = 1'b0;

   // Stage 2 logic
   assign mfull     = prod_ff >> SHIFT;
   assign m_in      = mfull[MW-1:0];
   assign m2_in     = m_in * m_in;
   assign f2_in.neg = f1_ff.neg;
   assign f2_in.big = (mfull >= THREE_FIX);

   // Stage 3 logic
   assign sum    = C27 + SUMW'(m2_ff);
   assign num_in = NUM_WIDTH'(m_ff) * NUM_WIDTH'(sum);
   assign den_in = DEN_WIDTH'(C27) + (DEN_WIDTH'(m2_ff) << 3) + DEN_WIDTH'(m2_ff);

   // Hold valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (r1) begin
            v1_ff <= in_valid;
         end
         if (r2) begin
            v2_ff <= v1_ff;
         end
         if (r3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (r1) begin
         prod_ff <= prod_in;
         f1_ff   <= f1_in;
      end
      if (r2) begin
         m_ff  <= m_in;
         m2_ff <= m2_in;
         f2_ff <= f2_in;
      end
      if (r3) begin
         num_ff <= num_in;
         den_ff <= den_in;
         f3_ff  <= f2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_flags = f3_ff;

endmodule

@@ rtl/core/rsc_div_stage.sv @@
// One restoring division step: decides one quotient bit and registers the item.
module rsc_div_stage #(
   parameter int NUM_WIDTH = 53,
   parameter int DEN_WIDTH = 37,
   parameter int QUO_WIDTH = 16,
   parameter int BIT_POS   = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [NUM_WIDTH-1:0]    in_rem,
   input  logic [DEN_WIDTH-1:0]    in_den,
   input  logic [QUO_WIDTH-1:0]    in_quo,
   input  rsc_pkg::flags_type      in_flags,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [NUM_WIDTH-1:0]    out_rem,
   output logic [DEN_WIDTH-1:0]    out_den,
   output logic [QUO_WIDTH-1:0]    out_quo,
   output rsc_pkg::flags_type      out_flags
);

   logic                 valid_ff;
   logic                 fits;
   logic [NUM_WIDTH-1:0] dshift;
   logic [NUM_WIDTH-1:0] rem_in, rem_ff;
   logic [DEN_WIDTH-1:0] den_ff;
   logic [QUO_WIDTH-1:0] quo_in, quo_ff;
   rsc_pkg::flags_type   flags_ff;

   assign in_ready = !valid_ff || out_ready;

   // Trial subtract of the shifted divisor
   assign dshift = NUM_WIDTH'(in_den) << BIT_POS;
   assign fits   = (in_rem >= dshift);

   always_comb begin
      rem_in = in_rem;
      quo_in = in_quo;
      if (fits) begin
         rem_in          = in_rem - dshift;
         quo_in[BIT_POS] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff   <= rem_in;
         den_ff   <= in_den;
         quo_ff   <= quo_in;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_flags = flags_ff;

endmodule

@@ rtl/core/rational_soft_clipper.sv @@
// Top level of the rational soft clipper: register port, curve pipeline, output stage.
//
// Each signed sample on the req_ channel is scaled by the drive gain and shaped
// by the rational curve x(27+x^2)/(27+9x^2), then returned on the rsp_ channel
// in the same format, saturated at full scale. Scaled magnitudes of three or
// more give full scale directly. Samples are independent; results leave in
// order, one per accepted item.
// From acceptance to rsp_valid an item passes three front stages (gain product,
// square, numerator and denominator products), one stage per quotient bit of
// the restoring divider, and the output register.
// Throughput: one item per cycle while rsp_ready is high; every stage holds
// its own valid bit.
// When the receiver holds rsp_ready low, the item waits in the output register
// and empty stages behind it keep filling; req_ready falls only once every
// stage holds an item. Nothing is dropped or repeated.
// Reset empties the pipeline and sets the drive gain to one half. Write the
// gain only while no item is in flight.
module rational_soft_clipper #(
   parameter int SAMPLE_WIDTH   = rsc_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int GAIN_FRAC_BITS = rsc_pkg::GAIN_FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_sample_out,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rsc_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [rsc_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [rsc_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready
);

   localparam int FRAC = SAMPLE_WIDTH - 1;
   localparam int WF   = rsc_pkg::work_frac(SAMPLE_WIDTH);
   localparam int NUMW = 3 * WF + 8;
   localparam int DENW = 2 * WF + 7;
   localparam int QW   = WF + 1;
   localparam logic [SAMPLE_WIDTH-1:0] POS_FULL = {1'b0, {FRAC{1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] NEG_FULL = {1'b1, {FRAC{1'b0}}};

   logic [rsc_pkg::GAIN_WIDTH-1:0] drive_gain;

   // Divider chain: index 0 is the front pipeline output
   logic               dv    [QW+1];
   logic               dready[QW+1];
   logic [NUMW-1:0]    drem  [QW+1];
   logic [DENW-1:0]    dden  [QW+1];
   logic [QW-1:0]      dquo  [QW+1];
   rsc_pkg::flags_type dflags[QW+1];

   // Output stage
   logic                    out_adv;
   logic                    sat;
   logic [SAMPLE_WIDTH-1:0] ym;
   logic [SAMPLE_WIDTH-1:0] sample_in;
   logic [SAMPLE_WIDTH-1:0] sample_ff;
   logic                    rsp_valid_ff;

   rsc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .drive_gain (drive_gain)
   );

   rsc_poly #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .NUM_WIDTH      (NUMW),
      .DEN_WIDTH      (DENW)
   ) u_poly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_sample (req_sample_in),
      .gain      (drive_gain),
      .out_valid (dv[0]),
      .out_ready (dready[0]),
      .out_num   (drem[0]),
      .out_den   (dden[0]),
      .out_flags (dflags[0])
   );

   assign dquo[0] = '0;

   // One quotient bit per stage, most significant first
   for (genvar j = 0; j < QW; j++) begin : g_div
      rsc_div_stage #(
         .NUM_WIDTH (NUMW),
         .DEN_WIDTH (DENW),
         .QUO_WIDTH (QW),
         .BIT_POS   (QW - 1 - j)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv[j]),
         .in_ready  (dready[j]),
         .in_rem    (drem[j]),
         .in_den    (dden[j]),
         .in_quo    (dquo[j]),
         .in_flags  (dflags[j]),
         .out_valid (dv[j+1]),
         .out_ready (dready[j+1]),
         .out_rem   (drem[j+1]),
         .out_den   (dden[j+1]),
         .out_quo   (dquo[j+1]),
         .out_flags (dflags[j+1])
      );
   end

   // Output register takes an item when empty or when the receiver takes its item
   assign dready[QW] = !rsp_valid_ff || rsp_ready;
   assign out_adv    = dv[QW] && dready[QW];

   // Saturate, rescale and restore the sign
   assign sat = dflags[QW].big || dquo[QW][QW-1];
   assign ym  = SAMPLE_WIDTH'(dquo[QW][WF-1:0]) << (FRAC - WF);

   always_comb begin
      if (sat) begin
         sample_in = dflags[QW].neg ? NEG_FULL : POS_FULL;
      end else begin
         sample_in = dflags[QW].neg ? (~ym + 1'b1) : ym;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dready[QW]) begin
         rsp_valid_ff <= dv[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         sample_ff <= sample_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = sample_ff;

   // Below three, the curve stays under one: the quotient overflow bit never sets
   a_curve_below_one: assert property (@(posedge clock) disable iff (reset)
      dv[QW] && !dflags[QW].big |-> !dquo[QW][QW-1])
      else $error("curve quotient reached one below the large-drive threshold");

   // Large drive leaves as full scale
   a_big_full_scale: assert property (@(posedge clock) disable iff (reset)
      out_adv && dflags[QW].big |=>
      rsp_valid && (rsp_sample_out == NEG_FULL || rsp_sample_out == POS_FULL))
      else $error("large-drive item did not leave at full scale");

   // A negative item never leaves as a positive value
   a_sign_kept: assert property (@(posedge clock) disable iff (reset)
      out_adv && dflags[QW].neg |=>
      rsp_sample_out[SAMPLE_WIDTH-1] || rsp_sample_out == '0)
      else $error("negative item left with a positive value");

endmodule
